// ===== src/mmc_pkg.sv =====
// Shared types and constants for the minimum merge cost interval DP block.
// Used by mmc_minscan, mmc_ctrl and the top level; depends on nothing else.
`default_nettype none

package mmc_pkg;

    localparam int MAX_ITEMS_DEF = 128;
    localparam int WEIGHT_W      = 32;
    localparam int COST_W        = 64;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic                last_item;
    } in_req_t;

    typedef struct packed {
        logic [COST_W-1:0] min_cost;
        logic              overflow;
    } out_req_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic diag_a;
        logic diag_b;
    } scan_ctl_t;

endpackage

`default_nettype wire

// ===== src/mmc_prefix_mem.sv =====
// Prefix sum memory: one write port and one registered read port.
// Generic storage, no package dependencies.
`default_nettype none

module mmc_prefix_mem #(
    parameter int DEPTH = 129,
    parameter int AW    = 8,
    parameter int DW    = 39
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/mmc_cost_mem.sv =====
// Cost table memory: one write port and two registered read ports.
// Generic storage, no package dependencies.
`default_nettype none

module mmc_cost_mem #(
    parameter int AW = 14,
    parameter int DW = 64
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr_a,
    input  wire logic [AW-1:0] raddr_b,
    output logic      [DW-1:0] rdata_a,
    output logic      [DW-1:0] rdata_b
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

// ===== src/mmc_minscan.sv =====
// Split-point scan pipeline: adds the two sub-interval costs and keeps the minimum.
// Depends on mmc_pkg for the scan control struct and cost width.
`default_nettype none

module mmc_minscan (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire mmc_pkg::scan_ctl_t        ctl,
    input  wire logic [mmc_pkg::COST_W-1:0] rd_a,
    input  wire logic [mmc_pkg::COST_W-1:0] rd_b,
    output logic                           busy,
    output logic      [mmc_pkg::COST_W-1:0] best
);

    mmc_pkg::scan_ctl_t             ctl1_reg;
    logic                           v2_reg;
    logic                           first2_reg;
    logic [mmc_pkg::COST_W-1:0]     sum_reg;
    logic [mmc_pkg::COST_W-1:0]     best_reg;
    logic [mmc_pkg::COST_W-1:0]     term_a;
    logic [mmc_pkg::COST_W-1:0]     term_b;

    assign term_a = ctl1_reg.diag_a ? '0 : rd_a;
    assign term_b = ctl1_reg.diag_b ? '0 : rd_b;
    assign busy   = ctl1_reg.valid || v2_reg;
    assign best   = best_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            v2_reg   <= 1'b0;
        end else begin
            ctl1_reg <= ctl;
            v2_reg   <= ctl1_reg.valid;
        end
        first2_reg <= ctl1_reg.first;
        sum_reg    <= term_a + term_b;
        if (v2_reg && (first2_reg || sum_reg < best_reg)) begin
            best_reg <= sum_reg;
        end
    end

endmodule

`default_nettype wire

// ===== src/mmc_ctrl.sv =====
// Sequencer for loading, the interval DP sweep and the result register.
// Depends on mmc_pkg; drives the prefix and cost memories and the scan pipeline.
`default_nettype none

module mmc_ctrl #(
    parameter int MAX_ITEMS = mmc_pkg::MAX_ITEMS_DEF,
    parameter int IDX_W     = $clog2(MAX_ITEMS),
    parameter int CNT_W     = $clog2(MAX_ITEMS + 1),
    parameter int PS_W      = mmc_pkg::WEIGHT_W + IDX_W
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire mmc_pkg::in_req_t           s_data,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output mmc_pkg::out_req_t               m_data,
    output logic                            ps_we,
    output logic      [CNT_W-1:0]           ps_waddr,
    output logic      [PS_W-1:0]            ps_wdata,
    output logic      [CNT_W-1:0]           ps_raddr,
    input  wire logic [PS_W-1:0]            ps_rdata,
    output logic                            cost_we,
    output logic      [2*IDX_W-1:0]         cost_waddr,
    output logic      [mmc_pkg::COST_W-1:0] cost_wdata,
    output logic      [2*IDX_W-1:0]         cost_raddr_a,
    output logic      [2*IDX_W-1:0]         cost_raddr_b,
    output mmc_pkg::scan_ctl_t              scan_ctl,
    input  wire logic                       scan_busy,
    input  wire logic [mmc_pkg::COST_W-1:0] scan_best
);

    typedef enum logic [2:0] {
        S_LOAD, S_SPAN0, S_SPAN1, S_SPAN2, S_SCAN, S_DRAIN, S_OUT
    } state_t;

    state_t                     state_reg;
    logic [CNT_W-1:0]           count_reg;
    logic                       ovf_reg;
    logic [PS_W-1:0]            run_sum_reg;
    logic [CNT_W-1:0]           n_reg;
    logic                       ovf_res_reg;
    logic [CNT_W-1:0]           len_reg;
    logic [IDX_W-1:0]           i_reg;
    logic [IDX_W-1:0]           k_reg;
    logic [PS_W-1:0]            hi_reg;
    logic [mmc_pkg::COST_W-1:0] span_reg;
    logic [mmc_pkg::COST_W-1:0] result_reg;
    logic                       m_valid_reg;
    mmc_pkg::out_req_t          m_data_reg;

    logic                       accept;
    logic                       room;
    logic [PS_W-1:0]            sum_in;
    logic [CNT_W-1:0]           count_after;
    logic [CNT_W-1:0]           j_wide;
    logic [IDX_W-1:0]           j_idx;
    logic [IDX_W-1:0]           k_inc;
    logic [PS_W-1:0]            low_sum;
    logic                       row_end;
    logic                       drain_done;

    assign s_ready     = (state_reg == S_LOAD);
    assign accept      = s_valid && s_ready;
    assign room        = count_reg < CNT_W'(MAX_ITEMS);
    assign sum_in      = run_sum_reg + PS_W'(s_data.weight);
    assign count_after = room ? count_reg + CNT_W'(1) : count_reg;

    assign j_wide  = CNT_W'(i_reg) + len_reg - CNT_W'(1);
    assign j_idx   = j_wide[IDX_W-1:0];
    assign k_inc   = k_reg + IDX_W'(1);
    assign low_sum = (i_reg == '0) ? '0 : ps_rdata;
    assign row_end = (CNT_W'(i_reg) + len_reg) == n_reg;

    assign ps_we    = accept && room;
    assign ps_waddr = count_reg + CNT_W'(1);
    assign ps_wdata = sum_in;
    assign ps_raddr = (state_reg == S_SPAN1) ? CNT_W'(i_reg) : j_wide + CNT_W'(1);

    assign cost_raddr_a = {i_reg, k_reg};
    assign cost_raddr_b = {k_inc, j_idx};

    assign scan_ctl.valid  = (state_reg == S_SCAN);
    assign scan_ctl.first  = (k_reg == i_reg);
    assign scan_ctl.diag_a = (k_reg == i_reg);
    assign scan_ctl.diag_b = (k_inc == j_idx);

    assign drain_done = (state_reg == S_DRAIN) && !scan_busy;
    assign cost_we    = drain_done;
    assign cost_waddr = {i_reg, j_idx};
    assign cost_wdata = scan_best + span_reg;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            run_sum_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_ready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_LOAD: begin
                    if (accept) begin
                        if (s_data.last_item) begin
                            n_reg       <= count_after;
                            ovf_res_reg <= ovf_reg || !room;
                            count_reg   <= '0;
                            ovf_reg     <= 1'b0;
                            run_sum_reg <= '0;
                            len_reg     <= CNT_W'(2);
                            i_reg       <= '0;
                            result_reg  <= '0;
                            if (count_after == CNT_W'(1)) begin
                                state_reg <= S_OUT;
                            end else begin
                                state_reg <= S_SPAN0;
                            end
                        end else begin
                            count_reg <= count_after;
                            ovf_reg   <= ovf_reg || !room;
                            if (room) begin
                                run_sum_reg <= sum_in;
                            end
                        end
                    end
                end
                S_SPAN0: begin
                    state_reg <= S_SPAN1;
                end
                S_SPAN1: begin
                    hi_reg    <= ps_rdata;
                    state_reg <= S_SPAN2;
                end
                S_SPAN2: begin
                    span_reg  <= mmc_pkg::COST_W'(hi_reg - low_sum);
                    k_reg     <= i_reg;
                    state_reg <= S_SCAN;
                end
                S_SCAN: begin
                    k_reg <= k_inc;
                    if (k_inc == j_idx) begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (drain_done) begin
                        if (len_reg == n_reg) begin
                            result_reg <= cost_wdata;
                            state_reg  <= S_OUT;
                        end else begin
                            if (row_end) begin
                                len_reg <= len_reg + CNT_W'(1);
                                i_reg   <= '0;
                            end else begin
                                i_reg <= i_reg + IDX_W'(1);
                            end
                            state_reg <= S_SPAN0;
                        end
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg         <= 1'b1;
                        m_data_reg.min_cost <= result_reg;
                        m_data_reg.overflow <= ovf_res_reg;
                        state_reg           <= S_LOAD;
                    end
                end
                default: begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("item count exceeds capacity");

    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LOAD) |-> !scan_busy)
        else $error("scan pipeline active while loading");

    a_write_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cost_we |-> $past(state_reg) == S_DRAIN)
        else $error("cost write without a finished scan");

    a_split_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (k_reg >= i_reg && k_reg < j_idx))
        else $error("split point outside the interval");

endmodule

`default_nettype wire

// ===== src/min_merge_cost_interval_dp_top.sv =====
// Top level of the minimum merge cost interval DP block.
// Depends on mmc_pkg, mmc_ctrl, mmc_minscan, mmc_prefix_mem and mmc_cost_mem.
//
// Usage: the s_ channel takes one request per element, a 32-bit weight
// and a last_item flag. While loading, one request is accepted every cycle.
// Elements beyond MAX_ITEMS are dropped and the result carries overflow.
// The request with last_item set closes the sequence and starts the
// computation; s_ready stays low until the result has been placed in the
// output register. Within an interval the sweep takes one split point per
// cycle, the rate that the cost table's two read ports allow; around each
// scan it computes the span sum and then drains the scan pipeline.
// A single element gives a cost of 0 and skips the sweep.
// The m_ channel presents one request with min_cost and overflow. If the
// receiver stalls, the result waits in the output register while the next
// sequence loads; the next result waits until the register is free.
// Reset clears the counters and state machine only; the memories need no
// clearing pass, since every entry whose value is used is written first.
`default_nettype none

module min_merge_cost_interval_dp_top #(
    parameter int MAX_ITEMS = mmc_pkg::MAX_ITEMS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire mmc_pkg::in_req_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output mmc_pkg::out_req_t      m_data
);

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int PS_W  = mmc_pkg::WEIGHT_W + IDX_W;

    logic                       ps_we;
    logic [CNT_W-1:0]           ps_waddr;
    logic [PS_W-1:0]            ps_wdata;
    logic [CNT_W-1:0]           ps_raddr;
    logic [PS_W-1:0]            ps_rdata;
    logic                       cost_we;
    logic [2*IDX_W-1:0]         cost_waddr;
    logic [mmc_pkg::COST_W-1:0] cost_wdata;
    logic [2*IDX_W-1:0]         cost_raddr_a;
    logic [2*IDX_W-1:0]         cost_raddr_b;
    logic [mmc_pkg::COST_W-1:0] cost_rdata_a;
    logic [mmc_pkg::COST_W-1:0] cost_rdata_b;
    mmc_pkg::scan_ctl_t         scan_ctl;
    logic                       scan_busy;
    logic [mmc_pkg::COST_W-1:0] scan_best;

    mmc_ctrl #(
        .MAX_ITEMS (MAX_ITEMS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W),
        .PS_W      (PS_W)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .ps_we        (ps_we),
        .ps_waddr     (ps_waddr),
        .ps_wdata     (ps_wdata),
        .ps_raddr     (ps_raddr),
        .ps_rdata     (ps_rdata),
        .cost_we      (cost_we),
        .cost_waddr   (cost_waddr),
        .cost_wdata   (cost_wdata),
        .cost_raddr_a (cost_raddr_a),
        .cost_raddr_b (cost_raddr_b),
        .scan_ctl     (scan_ctl),
        .scan_busy    (scan_busy),
        .scan_best    (scan_best)
    );

    mmc_minscan u_minscan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (scan_ctl),
        .rd_a    (cost_rdata_a),
        .rd_b    (cost_rdata_b),
        .busy    (scan_busy),
        .best    (scan_best)
    );

    mmc_prefix_mem #(
        .DEPTH (MAX_ITEMS + 1),
        .AW    (CNT_W),
        .DW    (PS_W)
    ) u_prefix_mem (
        .aclk  (aclk),
        .we    (ps_we),
        .waddr (ps_waddr),
        .wdata (ps_wdata),
        .raddr (ps_raddr),
        .rdata (ps_rdata)
    );

    mmc_cost_mem #(
        .AW (2 * IDX_W),
        .DW (mmc_pkg::COST_W)
    ) u_cost_mem (
        .aclk    (aclk),
        .we      (cost_we),
        .waddr   (cost_waddr),
        .wdata   (cost_wdata),
        .raddr_a (cost_raddr_a),
        .raddr_b (cost_raddr_b),
        .rdata_a (cost_rdata_a),
        .rdata_b (cost_rdata_b)
    );

endmodule

`default_nettype wire

// ===== test/tb_min_merge_cost_interval_dp_top.sv =====
// Testbench for min_merge_cost_interval_dp_top: a directed table, a capacity run and random
// weight sequences, each result checked against table costs or a DP cost predictor kept here.
// Depends on mmc_pkg and the block's RTL under src.
`timescale 1ns / 1ps

module tb_min_merge_cost_interval_dp_top;

    localparam int CAP         = mmc_pkg::MAX_ITEMS_DEF;
    localparam int N_DIR       = 22;
    localparam int RAND_ITEMS  = 40;
    localparam int STALL_LIMIT = 1600000;
    localparam int HOLD_LEN    = 3000;
    localparam int SETTLE      = 64;
    localparam int SHOWN_MAX   = 10;

    typedef enum int {W_FULL, W_TINY, W_EDGE, W_HIGH} weight_mode_t;

    typedef struct packed {
        logic [mmc_pkg::WEIGHT_W-1:0] weight;
        logic                         last_item;
        logic                         typed;
        logic [mmc_pkg::COST_W-1:0]   min_cost;
        logic                         overflow;
    } weight_row_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    mmc_pkg::in_req_t  s_data;
    logic              m_valid;
    logic              m_ready;
    mmc_pkg::out_req_t m_data;

    bit [mmc_pkg::WEIGHT_W-1:0] held_weights[$];
    bit                         held_overflow = 1'b0;
    longint unsigned            span_cost [CAP][CAP];
    mmc_pkg::out_req_t          pending_costs[$];
    weight_row_t                dir_tab [N_DIR];
    int                         fail_count   = 0;
    int                         idle_cycles  = 0;
    int                         hold_request = 0;
    bit                         send_steady  = 1'b0;
    bit                         take_steady  = 1'b0;

    min_merge_cost_interval_dp_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    function automatic longint unsigned merge_cost_of();
        longint unsigned psum [CAP+1];
        longint unsigned span;
        longint unsigned best;
        longint unsigned c;
        int n;
        int len;
        int i;
        int j;
        int k;
        n = held_weights.size();
        psum[0] = 0;
        for (i = 0; i < n; i++) begin
            psum[i+1] = psum[i] + 64'(held_weights[i]);
            span_cost[i][i] = 0;
        end
        for (len = 2; len <= n; len++) begin
            for (i = 0; i + len <= n; i++) begin
                j = i + len - 1;
                span = psum[j+1] - psum[i];
                best = 0;
                for (k = i; k < j; k++) begin
                    c = span_cost[i][k] + span_cost[k+1][j] + span;
                    if (k == i || c < best) begin
                        best = c;
                    end
                end
                span_cost[i][j] = best;
            end
        end
        return span_cost[0][n-1];
    endfunction

    task automatic note_accept(weight_row_t row);
        mmc_pkg::out_req_t res;
        if (held_weights.size() < CAP) begin
            held_weights = {held_weights, row.weight};
        end else begin
            held_overflow = 1'b1;
        end
        if (row.last_item) begin
            if (row.typed) begin
                res.min_cost = row.min_cost;
                res.overflow = row.overflow;
            end else begin
                res.min_cost = merge_cost_of();
                res.overflow = held_overflow;
            end
            pending_costs = {pending_costs, res};
            held_weights.delete();
            held_overflow = 1'b0;
        end
    endtask

    task automatic send_weight(weight_row_t row);
        int gap;
        gap = send_steady ? 0 : $urandom_range(0, 15);
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{weight: row.weight, last_item: row.last_item};
        do @(posedge aclk); while (s_ready !== 1'b1);
        note_accept(row);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_costs.size() != 0) @(posedge aclk);
    endtask

    function automatic weight_row_t rand_row(logic last_flag, weight_mode_t mode);
        logic [mmc_pkg::WEIGHT_W-1:0] w;
        case (mode)
            W_TINY: w = $urandom_range(0, 15);
            W_EDGE: w = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            W_HIGH: w = 32'hF000_0000 | $urandom();
            default: w = $urandom();
        endcase
        return '{w, last_flag, 1'b0, 64'd0, 1'b0};
    endfunction

    task automatic send_sequence(int n, weight_mode_t mode);
        int i;
        for (i = 0; i < n; i++) begin
            send_weight(rand_row(i == n - 1, mode));
        end
    endtask

    task automatic log_mismatch(string what, logic [mmc_pkg::COST_W-1:0] want,
                                logic [mmc_pkg::COST_W-1:0] got);
        fail_count++;
        if (fail_count <= SHOWN_MAX) begin
            $display("mismatch on %s: expected %0h, got %0h", what, want, got);
        end
    endtask

    task automatic check_result(mmc_pkg::out_req_t got);
        mmc_pkg::out_req_t want;
        if (pending_costs.size() == 0) begin
            log_mismatch("unexpected result", '0, got.min_cost);
        end else begin
            want = pending_costs.pop_front();
            if (got.min_cost !== want.min_cost) begin
                log_mismatch("min_cost", want.min_cost, got.min_cost);
            end
            if (got.overflow !== want.overflow) begin
                log_mismatch("overflow", mmc_pkg::COST_W'(want.overflow),
                             mmc_pkg::COST_W'(got.overflow));
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_request != 0) begin
                stall = hold_request;
                hold_request = 0;
            end else begin
                stall = take_steady ? 0 : $urandom_range(0, 15);
            end
            if ($urandom_range(0, 7) == 0) begin
                take_steady = !take_steady;
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            check_result(m_data);
        end
    end

    initial begin
        int rand_items;
        int n;
        int r;
        weight_mode_t mode;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        dir_tab = '{
            '{32'h0000_0000, 1'b1, 1'b1, 64'd0,                   1'b0},
            '{32'hFFFF_FFFF, 1'b1, 1'b1, 64'd0,                   1'b0},
            '{32'd5,         1'b0, 1'b0, 64'd0,                   1'b0},
            '{32'd7,         1'b1, 1'b1, 64'd12,                  1'b0},
            '{32'hFFFF_FFFF, 1'b0, 1'b0, 64'd0,                   1'b0},
            '{32'hFFFF_FFFF, 1'b1, 1'b1, 64'h0000_0001_FFFF_FFFE, 1'b0},
            '{32'h0000_0000, 1'b0, 1'b0, 64'd0,                   1'b0},
            '{32'h0000_0000, 1'b0, 1'b0, 64'd0,                   1'b0},
            '{32'h0000_0000, 1'b1, 1'b1, 64'd0,                   1'b0},
            '{32'd1,         1'b0, 1'b0, 64'd0,                   1'b0},
            '{32'd2,         1'b0, 1'b0, 64'd0,                   1'b0},
            '{32'd3,         1'b1, 1'b0, 64'd0,                   1'b0},
            '{32'h8000_0000, 1'b0, 1'b0, 64'd0,                   1'b0},
            '{32'h7FFF_FFFF, 1'b0, 1'b0, 64'd0,                   1'b0},
            '{32'hAAAA_AAAA, 1'b0, 1'b0, 64'd0,                   1'b0},
            '{32'h5555_5555, 1'b0, 1'b0, 64'd0,                   1'b0},
            '{32'hFFFF_FFFF, 1'b1, 1'b0, 64'd0,                   1'b0},
            '{32'd10,        1'b0, 1'b0, 64'd0,                   1'b0},
            '{32'd1,         1'b0, 1'b0, 64'd0,                   1'b0},
            '{32'd1,         1'b0, 1'b0, 64'd0,                   1'b0},
            '{32'd10,        1'b0, 1'b0, 64'd0,                   1'b0},
            '{32'd1,         1'b1, 1'b0, 64'd0,                   1'b0}
        };
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (r = 0; r < N_DIR; r++) begin
            send_weight(dir_tab[r]);
        end
        drain_results();

        // A sequence of maximum weights that runs two past capacity.
        for (r = 0; r < CAP + 2; r++) begin
            send_weight('{32'hFFFF_FFFF, r == CAP + 1, 1'b0, 64'd0, 1'b0});
        end
        drain_results();

        // The receiver holds off while short sequences keep arriving back to back.
        hold_request = HOLD_LEN;
        send_steady  = 1'b1;
        for (r = 0; r < 8; r++) begin
            send_sequence($urandom_range(1, 4), weight_mode_t'($urandom_range(0, 3)));
        end
        send_steady = 1'b0;
        drain_results();

        rand_items = 0;
        while (rand_items < RAND_ITEMS) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            mode = weight_mode_t'($urandom_range(0, 3));
            send_steady = ($urandom_range(0, 3) == 0);
            send_sequence(n, mode);
            rand_items += n;
            if ($urandom_range(0, 15) == 0) begin
                drain_results();
            end
        end
        drain_results();
        repeat (SETTLE) @(posedge aclk);

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/mmc_pkg.sv
src/mmc_prefix_mem.sv
src/mmc_cost_mem.sv
src/mmc_minscan.sv
src/mmc_ctrl.sv
src/min_merge_cost_interval_dp_top.sv
test/tb_min_merge_cost_interval_dp_top.sv
